// ----- hdl/slk_pkg.sv -----
`default_nettype none
package slk_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int COUNT_W   = 5;
	localparam int ADDR_W    = $clog2(CAPACITY);

	typedef struct packed {
		logic                        action;
		logic signed [KEY_WIDTH-1:0] key;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [COUNT_W-1:0] count;
	} rsp_t;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_RM_RD,
		ST_RM_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DEL,
		ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		RA_PREV,
		RA_CUR,
		RA_NEXT
	} rd_sel_t;

	typedef enum logic {
		WR_RDATA,
		WR_KEY
	} wr_src_t;

	typedef struct packed {
		logic    load;
		logic    idx_inc;
		logic    idx_dec;
		rd_sel_t rd_sel;
		logic    wr_en;
		wr_src_t wr_src;
		logic    cnt_inc;
		logic    cnt_dec;
		logic    ok_set;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic gt;
		logic eq;
		logic idx_one;
		logic last;
		logic last2;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ----- hdl/slk_dp.sv -----
`default_nettype none
module slk_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire slk_pkg::req_t req,
	input  wire slk_pkg::cmd_t cmd,
	output slk_pkg::sts_t      sts,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output slk_pkg::rsp_t      rsp
);

	logic signed [slk_pkg::KEY_WIDTH-1:0] mem [slk_pkg::CAPACITY];

	logic signed [slk_pkg::KEY_WIDTH-1:0] key_q;
	logic signed [slk_pkg::KEY_WIDTH-1:0] rdata_q;
	logic [slk_pkg::COUNT_W-1:0]          idx_q;
	logic [slk_pkg::COUNT_W-1:0]          count_q;
	logic                                 ok_q;
	logic                                 rsp_valid_q;
	slk_pkg::rsp_t                        rsp_q;

	logic [slk_pkg::COUNT_W-1:0]          rd_idx;
	logic [slk_pkg::ADDR_W-1:0]           raddr;
	logic [slk_pkg::ADDR_W-1:0]           waddr;
	logic signed [slk_pkg::KEY_WIDTH-1:0] wdata;

	always_comb begin
		case (cmd.rd_sel)
			slk_pkg::RA_PREV: rd_idx = idx_q - slk_pkg::COUNT_W'(1);
			slk_pkg::RA_CUR:  rd_idx = idx_q;
			slk_pkg::RA_NEXT: rd_idx = idx_q + slk_pkg::COUNT_W'(1);
			default:          rd_idx = idx_q;
		endcase
	end

	assign raddr = rd_idx[slk_pkg::ADDR_W-1:0];
	assign waddr = idx_q[slk_pkg::ADDR_W-1:0];
	assign wdata = (cmd.wr_src == slk_pkg::WR_KEY) ? key_q : rdata_q;

	// single-port style array: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= req.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			count_q     <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				// insert scans down from the top, remove scans up from the bottom
				idx_q <= (req.action == slk_pkg::ACT_REMOVE) ? '0 : count_q;
				ok_q  <= 1'b0;
			end else begin
				if (cmd.idx_inc) idx_q <= idx_q + slk_pkg::COUNT_W'(1);
				if (cmd.idx_dec) idx_q <= idx_q - slk_pkg::COUNT_W'(1);
				if (cmd.ok_set)  ok_q  <= 1'b1;
			end
			if (cmd.cnt_inc) count_q <= count_q + slk_pkg::COUNT_W'(1);
			if (cmd.cnt_dec) count_q <= count_q - slk_pkg::COUNT_W'(1);
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.ok    <= ok_q;
			rsp_q.count <= count_q;
		end
	end

	assign sts.full     = (count_q == slk_pkg::COUNT_W'(slk_pkg::CAPACITY));
	assign sts.empty    = (count_q == '0);
	assign sts.gt       = (rdata_q > key_q);
	assign sts.eq       = (rdata_q == key_q);
	assign sts.idx_one  = (idx_q == slk_pkg::COUNT_W'(1));
	assign sts.last     = ((idx_q + slk_pkg::COUNT_W'(1)) == count_q);
	assign sts.last2    = ((idx_q + slk_pkg::COUNT_W'(2)) == count_q);
	assign sts.out_free = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slk_pkg::COUNT_W'(slk_pkg::CAPACITY))
		else $error("entry count above capacity");

	a_inc_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |=> count_q == $past(count_q) + slk_pkg::COUNT_W'(1))
		else $error("count did not step on insert");

	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> !sts.full && cmd.wr_en && cmd.wr_src == slk_pkg::WR_KEY)
		else $error("insert commit without room or key write");

endmodule
`default_nettype wire

// ----- hdl/slk_ctrl.sv -----
`default_nettype none
module slk_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire logic          req_action,
	input  wire slk_pkg::sts_t sts,
	output slk_pkg::cmd_t      cmd
);

	slk_pkg::state_t state_q;
	slk_pkg::state_t state_d;
	logic            accept;

	assign req_ready = (state_q == slk_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slk_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			slk_pkg::ST_IDLE: begin
				if (accept) begin
					if (req_action == slk_pkg::ACT_REMOVE) begin
						state_d = sts.empty ? slk_pkg::ST_FIN : slk_pkg::ST_RM_RD;
					end else if (sts.full) begin
						state_d = slk_pkg::ST_FIN;
					end else begin
						state_d = sts.empty ? slk_pkg::ST_INS_PUT : slk_pkg::ST_INS_RD;
					end
				end
			end
			slk_pkg::ST_INS_RD:  state_d = slk_pkg::ST_INS_CMP;
			slk_pkg::ST_INS_CMP: begin
				if (sts.gt && !sts.idx_one) begin
					state_d = slk_pkg::ST_INS_RD;
				end else begin
					state_d = slk_pkg::ST_INS_PUT;
				end
			end
			slk_pkg::ST_INS_PUT: state_d = slk_pkg::ST_FIN;
			slk_pkg::ST_RM_RD:   state_d = slk_pkg::ST_RM_CMP;
			slk_pkg::ST_RM_CMP: begin
				if (sts.eq) begin
					state_d = sts.last ? slk_pkg::ST_DEL : slk_pkg::ST_SH_RD;
				end else begin
					state_d = sts.last ? slk_pkg::ST_FIN : slk_pkg::ST_RM_RD;
				end
			end
			slk_pkg::ST_SH_RD:   state_d = slk_pkg::ST_SH_WR;
			slk_pkg::ST_SH_WR:   state_d = sts.last2 ? slk_pkg::ST_DEL : slk_pkg::ST_SH_RD;
			slk_pkg::ST_DEL:     state_d = slk_pkg::ST_FIN;
			slk_pkg::ST_FIN: begin
				if (sts.out_free) state_d = slk_pkg::ST_IDLE;
			end
			default:             state_d = slk_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = slk_pkg::RA_CUR;
		cmd.wr_src = slk_pkg::WR_RDATA;
		case (state_q)
			slk_pkg::ST_IDLE:    cmd.load = accept;
			slk_pkg::ST_INS_RD:  cmd.rd_sel = slk_pkg::RA_PREV;
			slk_pkg::ST_INS_CMP: begin
				// larger neighbor moves up one slot
				if (sts.gt) begin
					cmd.wr_en   = 1'b1;
					cmd.idx_dec = 1'b1;
				end
			end
			slk_pkg::ST_INS_PUT: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_src  = slk_pkg::WR_KEY;
				cmd.cnt_inc = 1'b1;
				cmd.ok_set  = 1'b1;
			end
			slk_pkg::ST_RM_RD:   cmd.rd_sel = slk_pkg::RA_CUR;
			slk_pkg::ST_RM_CMP:  cmd.idx_inc = !sts.eq;
			slk_pkg::ST_SH_RD:   cmd.rd_sel = slk_pkg::RA_NEXT;
			slk_pkg::ST_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			slk_pkg::ST_DEL: begin
				cmd.cnt_dec = 1'b1;
				cmd.ok_set  = 1'b1;
			end
			slk_pkg::ST_FIN:     cmd.out_load = sts.out_free;
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != slk_pkg::ST_IDLE)
		else $error("accepted beat left controller idle");

endmodule
`default_nettype wire

// ----- hdl/sorted_key_list_top.sv -----
`default_nettype none
// Sorted key list: holds up to 16 signed 32-bit keys in ascending order in an
// array with a registered read. A req beat with action 0 inserts its key after
// any equal keys; action 1 removes the first equal key. Each beat yields one
// rsp beat with ok and the count held afterwards. Every entry visited costs a
// read step, then a compare-and-move step. An insert visits entries from the
// top down, moving each one greater than the key up one slot, then writes the
// key; a remove reads entries from the bottom until it finds its key, then
// shifts every entry above it down one slot, or on a miss reads every entry
// held. The longest operation is a remove from a full list; a full-list insert
// or an empty-list remove goes straight to loading the rsp beat. After loading
// the rsp beat the controller returns to idle, ready for the next req beat.
// A new req beat is taken while the previous rsp beat still waits, but the
// next rsp beat is held back until that one is taken.
module sorted_key_list_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire slk_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output slk_pkg::rsp_t      rsp
);

	slk_pkg::cmd_t cmd;
	slk_pkg::sts_t sts;

	slk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_action (req.action),
		.sts        (sts),
		.cmd        (cmd)
	);

	slk_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
